// ===== src/skl_pkg.sv =====
// Shared types and constants for the sorted candidate list.
// No dependencies; imported by skl_cell and sorted_knn_list_insert.
`timescale 1ns / 1ps
package skl_pkg;

   localparam int LIST_DEPTH = 64;
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
   localparam int CAP_W      = 7;
   localparam int ID_W       = 32;
   localparam int KEY_W      = 32;
   localparam int OP_W       = 2;
   localparam int STATUS_W   = 3;
   localparam int RIDX_W     = 6;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_READ   = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DROPPED   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_READ_OK   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_READ_EMPTY= 3'd4;
   localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd5;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic             eval_en;
      logic             wr_en;
      logic [CNT_W-1:0] fill;
      logic [CNT_W-1:0] pos;
      logic [CNT_W-1:0] last;
      logic [ID_W-1:0]  id;
      logic [KEY_W-1:0] key;
   } skl_cmd_type;

   // Compare flags a cell reports back.
   typedef struct packed {
      logic le;
      logic dup;
   } skl_flag_type;

endpackage

// ===== src/skl_cell.sv =====
// One slot of the sorted list: holds an id/key pair and its compare flags.
// Depends on skl_pkg.
`timescale 1ns / 1ps
module skl_cell
   import skl_pkg::*;
(
   input  logic                clock,
   input  logic [CNT_W-1:0]    cell_index,
   input  skl_cmd_type         cmd,
   input  logic [ID_W-1:0]     prev_id,
   input  logic [KEY_W-1:0]    prev_key,
   output logic [ID_W-1:0]     cell_id,
   output logic [KEY_W-1:0]    cell_key,
   output skl_flag_type        flags
);

   logic [ID_W-1:0]  id_ff,  id_in;
   logic [KEY_W-1:0] key_ff, key_in;
   skl_flag_type     flag_ff, flag_in;
   logic             in_use;

   always_comb begin
      in_use  = cell_index < cmd.fill;
      flag_in = flag_ff;
      id_in   = id_ff;
      key_in  = key_ff;
      if (cmd.eval_en) begin
         flag_in.le  = in_use && (key_ff <= cmd.key);
         flag_in.dup = in_use && (key_ff == cmd.key) && (id_ff == cmd.id);
      end
      if (cmd.wr_en) begin
         // load the candidate at its slot, shift the tail one place down
         if (cell_index == cmd.pos) begin
            id_in  = cmd.id;
            key_in = cmd.key;
         end else if ((cell_index > cmd.pos) && (cell_index <= cmd.last)) begin
            id_in  = prev_id;
            key_in = prev_key;
         end
      end
   end

   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      key_ff  <= key_in;
      flag_ff <= flag_in;
   end

   assign cell_id  = id_ff;
   assign cell_key = key_ff;
   assign flags    = flag_ff;

endmodule

// ===== src/sorted_knn_list_insert.sv =====
// Top level of the sorted top-k candidate list: controller, row of cells, result register.
// Depends on skl_pkg and skl_cell.
`timescale 1ns / 1ps
// Usage:
//   req channel: one operation per transfer. req_tuser carries the op code
//     (insert, read, clear); req_tdata carries cand_id, cand_key, read_index.
//   rsp channel: one result per insert, read or clear; status in rsp_tuser,
//     position, fill_count, out_id, out_key in rsp_tdata. Op code 3 is
//     accepted and produces no result.
//   csr port: csr_we writes capacity (clamped to 1..64 when used).
// Timing: a request goes through capture, compare and commit before its
//   result shows on rsp_tvalid: capture registers the request, compare
//   latches every cell's compare flags, and commit encodes the insertion
//   slot, shifts the cells in parallel and loads the rsp register. Commit
//   waits while the rsp register is still full. req_tready stays low from
//   the transfer until commit, so no new request is taken before it commits.
// Reset: the list is empty, capacity is 64, no result is pending.
// Stall: a finished result waits in the rsp register; the next operation is
//   accepted and evaluated meanwhile and holds at commit until the register
//   frees up.
module sorted_knn_list_insert
   import skl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   // configuration
   input  logic          csr_we,
   input  logic [6:0]    csr_wdata,   // capacity
   // request channel
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [1:0]    req_tuser,   // [1:0] op
   input  logic [71:0]   req_tdata,   // [31:0] cand_id, [63:32] cand_key,
                                      // [69:64] read_index, [71:70] zero
   // response channel
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [2:0]    rsp_tuser,   // [2:0] status
   output logic [79:0]   rsp_tdata    // [6:0] position, [13:7] fill_count,
                                      // [45:14] out_id, [77:46] out_key,
                                      // [79:78] zero
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_EVAL   = 2'd1;
   localparam logic [1:0] S_COMMIT = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CAP_W-1:0]    cap_ff, cap_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   // captured request
   logic [OP_W-1:0]     op_ff, op_in;
   logic [ID_W-1:0]     cid_ff, cid_in;
   logic [KEY_W-1:0]    ckey_ff, ckey_in;
   logic [RIDX_W-1:0]   ridx_ff, ridx_in;

   // result register
   logic                rvalid_ff, rvalid_in;
   logic [STATUS_W-1:0] rstat_ff, rstat_in;
   logic [CNT_W-1:0]    rpos_ff, rpos_in;
   logic [CNT_W-1:0]    rfill_ff, rfill_in;
   logic [ID_W-1:0]     rid_ff, rid_in;
   logic [KEY_W-1:0]    rkey_ff, rkey_in;

   // cell row
   skl_cmd_type         cmd;
   logic [ID_W-1:0]     row_id  [LIST_DEPTH];
   logic [KEY_W-1:0]    row_key [LIST_DEPTH];
   skl_flag_type        row_flag[LIST_DEPTH];

   logic [CNT_W-1:0]    cap_eff, fill_n, pos, last, ridx_ext;
   logic                dup_any, ins_ok, commit_go, rd_hit, accept;
   logic [ID_W-1:0]     rd_id;
   logic [KEY_W-1:0]    rd_key;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign commit_go  = (state_ff == S_COMMIT) && (!rvalid_ff || rsp_tready);
   assign ridx_ext   = CNT_W'(ridx_ff);

   // effective capacity and fill after truncation to it
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CNT_W'(1);
      end else if (int'(cap_ff) > LIST_DEPTH) begin
         cap_eff = CNT_W'(LIST_DEPTH);
      end else begin
         cap_eff = CNT_W'(cap_ff);
      end
      fill_n = (count_ff > cap_eff) ? cap_eff : count_ff;
      last   = (fill_n < cap_eff) ? fill_n : cap_eff - CNT_W'(1);
   end

   // The le flags form a thermometer over the used slots; its falling edge
   // marks the insertion slot. Encode it as a binary index, and gather read data.
   always_comb begin
      logic nxt;
      pos     = '0;
      dup_any = 1'b0;
      rd_id   = '0;
      rd_key  = '0;
      for (int j = 0; j < LIST_DEPTH; j++) begin
         nxt = (j == LIST_DEPTH - 1) ? 1'b0 : row_flag[(j + 1) % LIST_DEPTH].le;
         if (row_flag[j].le && !nxt) begin
            pos = pos | CNT_W'(j + 1);
         end
         dup_any = dup_any | row_flag[j].dup;
         if (CNT_W'(j) == ridx_ext) begin
            rd_id  = rd_id  | row_id[j];
            rd_key = rd_key | row_key[j];
         end
      end
      rd_hit = ridx_ext < count_ff;
      ins_ok = !dup_any && (pos < cap_eff);
   end

   always_comb begin
      cmd.eval_en = (state_ff == S_EVAL) && (op_ff == OP_INSERT);
      cmd.wr_en   = commit_go && (op_ff == OP_INSERT) && ins_ok;
      cmd.fill    = fill_n;
      cmd.pos     = pos;
      cmd.last    = last;
      cmd.id      = cid_ff;
      cmd.key     = ckey_ff;
   end

   for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
      skl_cell u_cell (
         .clock      (clock),
         .cell_index (CNT_W'(g)),
         .cmd        (cmd),
         .prev_id    ((g == 0) ? cid_ff  : row_id[(g + LIST_DEPTH - 1) % LIST_DEPTH]),
         .prev_key   ((g == 0) ? ckey_ff : row_key[(g + LIST_DEPTH - 1) % LIST_DEPTH]),
         .cell_id    (row_id[g]),
         .cell_key   (row_key[g]),
         .flags      (row_flag[g])
      );
   end

   // sequencer, fill count and result register
   always_comb begin
      state_in  = state_ff;
      cap_in    = csr_we ? csr_wdata : cap_ff;
      count_in  = count_ff;
      op_in     = op_ff;
      cid_in    = cid_ff;
      ckey_in   = ckey_ff;
      ridx_in   = ridx_ff;
      rvalid_in = rvalid_ff && !rsp_tready;
      rstat_in  = rstat_ff;
      rpos_in   = rpos_ff;
      rfill_in  = rfill_ff;
      rid_in    = rid_ff;
      rkey_in   = rkey_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_tuser;
               cid_in   = req_tdata[31:0];
               ckey_in  = req_tdata[63:32];
               ridx_in  = req_tdata[69:64];
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (commit_go) begin
               state_in = S_IDLE;
               rid_in   = '0;
               rkey_in  = '0;
               case (op_ff)
                  OP_INSERT: begin
                     rvalid_in = 1'b1;
                     rpos_in   = pos;
                     if (dup_any) begin
                        rstat_in = ST_DUPLICATE;
                        count_in = fill_n;
                     end else if (!ins_ok) begin
                        rstat_in = ST_DROPPED;
                        count_in = fill_n;
                     end else begin
                        rstat_in = ST_INSERTED;
                        count_in = (fill_n < cap_eff) ? fill_n + CNT_W'(1) : cap_eff;
                     end
                     rfill_in = count_in;
                  end
                  OP_READ: begin
                     rvalid_in = 1'b1;
                     rpos_in   = ridx_ext;
                     rfill_in  = count_ff;
                     if (rd_hit) begin
                        rstat_in = ST_READ_OK;
                        rid_in   = rd_id;
                        rkey_in  = rd_key;
                     end else begin
                        rstat_in = ST_READ_EMPTY;
                     end
                  end
                  OP_CLEAR: begin
                     rvalid_in = 1'b1;
                     rstat_in  = ST_CLEARED;
                     rpos_in   = '0;
                     rfill_in  = '0;
                     count_in  = '0;
                  end
                  default: begin
                     // unused op: drop without a result
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cap_ff    <= CAP_W'(LIST_DEPTH);
         count_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cap_ff    <= cap_in;
         count_ff  <= count_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      cid_ff   <= cid_in;
      ckey_ff  <= ckey_in;
      ridx_ff  <= ridx_in;
      rstat_ff <= rstat_in;
      rpos_ff  <= rpos_in;
      rfill_ff <= rfill_in;
      rid_ff   <= rid_in;
      rkey_ff  <= rkey_in;
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tuser  = rstat_ff;
   assign rsp_tdata  = {2'b00, rkey_ff, rid_ff, 7'(rfill_ff), 7'(rpos_ff)};

endmodule
